// ----- rtl/fixed_width_bit_packer_unit_assert.svh -----
// Assertion macros shared by the bit packer modules.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef FIXED_WIDTH_BIT_PACKER_UNIT_ASSERT_SVH
`define FIXED_WIDTH_BIT_PACKER_UNIT_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define FWBP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define FWBP_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ----- rtl/fwbp_pkg.sv -----
// ----------------------------------------------------------------------------
// fwbp_pkg
// Widths, reset values and the item type passed from the packing stage to
// the byte drain of the fixed width bit packer.
// ----------------------------------------------------------------------------
package fwbp_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned ValueW  = 31;
  localparam int unsigned WidthW  = 5;
  localparam int unsigned PendW   = 7;
  localparam int unsigned PendCntW = 3;
  // Up to four full bytes plus the flush byte per item
  localparam int unsigned MaxBytes = 5;
  localparam int unsigned AccW    = MaxBytes * ByteW;
  localparam int unsigned NumW    = 3;

  localparam logic [WidthW-1:0] WidthReset = 5'd8;

  // One packed item: its bytes lowest first, the byte count and the flush flag
  typedef struct packed {
    logic [AccW-1:0] bytes;
    logic [NumW-1:0] num;
    logic            last;
  } pack_item_t;

endpackage

// ----- rtl/fwbp_pack_core.sv -----
// ----------------------------------------------------------------------------
// fwbp_pack_core
// Holds the value width and the leftover bits, merges each accepted value
// into them and hands the completed bytes on as one item.
// ----------------------------------------------------------------------------
`include "fixed_width_bit_packer_unit_assert.svh"

module fwbp_pack_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [fwbp_pkg::WidthW-1:0]   cfg_width_i,
  input  logic                          accept_i,
  input  logic [fwbp_pkg::ValueW-1:0]   value_i,
  input  logic                          last_i,
  output fwbp_pkg::pack_item_t          item_o
);

  logic [fwbp_pkg::WidthW-1:0]   width_q;
  logic [fwbp_pkg::PendW-1:0]    pend_q, pend_d;
  logic [fwbp_pkg::PendCntW-1:0] pend_cnt_q, pend_cnt_d;

  logic [fwbp_pkg::ValueW-1:0]   masked;
  logic [fwbp_pkg::AccW-1:0]     acc;
  logic [fwbp_pkg::AccW-1:0]     tail;
  logic [5:0]                    total;
  logic [fwbp_pkg::NumW-1:0]     num_full;

  // Drop value bits at and above the width, then append after leftover bits
  always_comb begin
    masked   = value_i & ~({fwbp_pkg::ValueW{1'b1}} << width_q);
    acc      = {{(fwbp_pkg::AccW - fwbp_pkg::PendW){1'b0}}, pend_q}
             | ({{(fwbp_pkg::AccW - fwbp_pkg::ValueW){1'b0}}, masked} << pend_cnt_q);
    total    = {3'b000, pend_cnt_q} + {1'b0, width_q};
    num_full = total[5:3];
    tail     = acc >> {num_full, 3'b000};
  end

  // Build the outgoing item; the flush byte is the tail after the full bytes
  always_comb begin
    item_o.bytes = acc;
    item_o.num   = num_full + {2'b00, last_i};
    item_o.last  = last_i;
  end

  // Keep the leftover bits, or restart on a byte boundary after a flush
  always_comb begin
    pend_d     = pend_q;
    pend_cnt_d = pend_cnt_q;
    if (accept_i) begin
      if (last_i) begin
        pend_d     = '0;
        pend_cnt_d = '0;
      end else begin
        pend_d     = tail[fwbp_pkg::PendW-1:0];
        pend_cnt_d = total[2:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= fwbp_pkg::WidthReset;
      pend_q     <= '0;
      pend_cnt_q <= '0;
    end else begin
      if (cfg_we_i) begin
        width_q <= cfg_width_i;
      end
      pend_q     <= pend_d;
      pend_cnt_q <= pend_cnt_d;
    end
  end

  `FWBP_ASSERT(a_flush_clears, (accept_i && last_i) |=> (pend_cnt_q == '0 && pend_q == '0), "leftover bits survive a flush")
  `FWBP_ASSERT(a_idle_holds, !accept_i |=> $stable(pend_cnt_q), "leftover count moved without an item")

endmodule

// ----- rtl/fwbp_byte_drain.sv -----
// ----------------------------------------------------------------------------
// fwbp_byte_drain
// Output register of the packer: takes one packed item and presents its
// bytes one per cycle while tready_i is high, lowest first, marking the flush byte.
// ----------------------------------------------------------------------------
`include "fixed_width_bit_packer_unit_assert.svh"

module fwbp_byte_drain (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        load_i,
  input  fwbp_pkg::pack_item_t        item_i,
  output logic                        can_load_o,
  output logic                        tvalid_o,
  input  logic                        tready_i,
  output logic [fwbp_pkg::ByteW-1:0]  tdata_o,
  output logic                        tlast_o
);

  logic [fwbp_pkg::AccW-1:0] data_q, data_d;
  logic [fwbp_pkg::NumW-1:0] num_q, num_d;
  logic                      last_q, last_d;
  logic                      pop;

  assign pop        = tvalid_o && tready_i;
  // Free now, or the final byte leaves in this cycle
  assign can_load_o = (num_q == '0) || (num_q == 3'd1 && tready_i);

  assign tvalid_o = (num_q != '0);
  assign tdata_o  = data_q[fwbp_pkg::ByteW-1:0];
  assign tlast_o  = last_q && (num_q == 3'd1);

  // Load a new item or advance to the next byte
  always_comb begin
    data_d = data_q;
    num_d  = num_q;
    last_d = last_q;
    if (load_i) begin
      data_d = item_i.bytes;
      num_d  = item_i.num;
      last_d = item_i.last;
    end else if (pop) begin
      data_d = data_q >> fwbp_pkg::ByteW;
      num_d  = num_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q  <= '0;
      last_q <= 1'b0;
    end else begin
      num_q  <= num_d;
      last_q <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  `FWBP_ASSERT_NEVER(a_num_range, num_q > 3'd5, "byte count above five")
  `FWBP_ASSERT_NEVER(a_load_over_busy, load_i && num_q > 3'd1, "item loaded over pending bytes")
  `FWBP_ASSERT(a_pop_step, (pop && !load_i) |=> (num_q == $past(num_q) - 3'd1), "byte count did not step")

endmodule

// ----- rtl/fixed_width_bit_packer_unit.sv -----
// ----------------------------------------------------------------------------
// fixed_width_bit_packer_unit
// Packs unsigned values of a configured width, LSB first, into a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//  - Input items on s_axis: tdata carries the value (bit 31 unused), tlast
//    marks the final value of an array.
//  - Output items on m_axis: one byte per item, tlast on the flush byte that
//    closes an array (leftover bits zero-padded, or zero on a byte boundary).
//  - cfg_valid/cfg_ready/cfg_data_i write the value width (1..31); write it
//    only while no bytes are pending. cfg_ready is always high.
// The first byte of an item appears in the cycle after it is accepted.
// Throughput: an item producing k bytes (k = 0..5) holds the output register
//   until its last byte is taken; an item that yields at most one byte can
//   follow in the next cycle. The next item is taken in the cycle its predecessor's
//   last byte leaves, so the output port, one byte per cycle while m_axis_tready is
//   high, sets the rate. Reset: width returns to 8, leftover bits are cleared, no bytes pending.
// Stall: while m_axis_tready is low the current byte holds and s_axis_tready
//   drops until the final byte of the current item is taken.
// ----------------------------------------------------------------------------
module fixed_width_bit_packer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data_i,      // value_width
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,    // [30:0] value, [31] zero pad
  input  logic        s_axis_tlast,    // last_value
  // Output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,    // [7:0] out_byte
  output logic        m_axis_tlast     // last_byte
);

  fwbp_pkg::pack_item_t item;
  logic                 accept;
  logic                 can_load;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = can_load;
  assign accept        = s_axis_tvalid && can_load;

  // Merge values into the bit stream
  fwbp_pack_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid),
    .cfg_width_i (cfg_data_i),
    .accept_i    (accept),
    .value_i     (s_axis_tdata[fwbp_pkg::ValueW-1:0]),
    .last_i      (s_axis_tlast),
    .item_o      (item)
  );

  // Present the completed bytes
  fwbp_byte_drain u_drain (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (accept),
    .item_i     (item),
    .can_load_o (can_load),
    .tvalid_o   (m_axis_tvalid),
    .tready_i   (m_axis_tready),
    .tdata_o    (m_axis_tdata),
    .tlast_o    (m_axis_tlast)
  );

endmodule
